>>> rtl/core/pbd_pkg.sv
// Package for the premultiplied box downscaler core.
// Holds the input and result item types and the configuration register indexes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pbd_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/premultiplied_box_downscaler_core.sv
// Top level of the premultiplied box downscaler: pixel store, box walker and
// one shared restoring divider under a small sequencer.
// Depends on pbd_pkg for the item types and register indexes.
//
// Usage: a load item (mode 0) writes one straight RGBA source pixel into the
// pixel store. A compute item (mode 1) names a destination pixel; the block
// finds its source box, walks it through the store one pixel a cycle, and
// returns one result item with the un-premultiplied mean colour and the mean
// alpha. Every division (four for the box bounds, four for the result) runs
// on the same divider, one quotient bit a cycle; the dividend is 31 bits wide
// at the default SRC_DIM. A destination pixel outside the destination size
// needs only the four bound divisions, and a box whose alpha sums to zero
// skips the four result divisions; both return zeros. in_ready is low while
// a compute item is at work. The result sits in an output register; when
// the receiver stalls, a finished item waits for that register to free, and
// new items are accepted as soon as it is loaded. Reset clears the sequencer
// and restores the size registers; the pixel store keeps no reset and must
// be written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module premultiplied_box_downscaler_core
  import pbd_pkg::*;
#(
  parameter int SRC_DIM = 128,
  parameter int DST_DIM = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_item,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_item,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH  = SRC_DIM * SRC_DIM;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW_W   = $clog2(SRC_DIM + 1);
  localparam int DW_W   = $clog2(DST_DIM + 1);
  localparam int NW     = $clog2(DEPTH + 1);
  localparam int SUMA_W = NW + 8;
  localparam int SUMC_W = NW + 16;
  localparam int PROD_W = 9 + SW_W;
  localparam int DVW    = (SUMC_W > PROD_W) ? SUMC_W : PROD_W;
  localparam int DSW    = (SUMA_W > DW_W) ? SUMA_W : DW_W;
  localparam int CNT_W  = $clog2(DVW + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_SPAN,
    ST_WALK,
    ST_DRAIN,
    ST_TEST,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_X0,
    OP_X1,
    OP_Y0,
    OP_Y1,
    OP_R,
    OP_G,
    OP_B,
    OP_A
  } op_t;

  state_t state;
  op_t    op;

  logic [7:0] src_width;
  logic [7:0] src_height;
  logic [8:0] dst_width;
  logic [8:0] dst_height;

  logic [7:0] col_r;
  logic [7:0] row_r;

  logic [SW_W-1:0] sw;
  logic [SW_W-1:0] sh;
  logic [DW_W-1:0] dw;
  logic [DW_W-1:0] dh;

  logic [DVW-1:0]   div_q;
  logic [DSW-1:0]   div_rem;
  logic [DSW-1:0]   div_d;
  logic [CNT_W-1:0] div_cnt;
  logic [DSW:0]     rem_sh;
  logic             rem_ge;

  logic [8:0]        mul_a;
  logic [SW_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod;
  logic [DVW-1:0]    dividend;
  logic [DSW-1:0]    divisor;

  logic [DVW-1:0] q_x0;
  logic [DVW-1:0] q_x1;
  logic [DVW-1:0] q_y0;
  logic [DVW-1:0] q_y1;

  logic [DVW-1:0]  x1_raw;
  logic [DVW-1:0]  y1_raw;
  logic [SW_W-1:0] x1_lim;
  logic [SW_W-1:0] y1_lim;

  logic [SW_W-1:0] x0;
  logic [SW_W-1:0] x1;
  logic [SW_W-1:0] y1;
  logic [SW_W-1:0] sx;
  logic [SW_W-1:0] sy;

  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [31:0]   rd_data;
  logic          rd_valid;
  logic [31:0]   wr_word;

  logic [SUMC_W-1:0] sum_r;
  logic [SUMC_W-1:0] sum_g;
  logic [SUMC_W-1:0] sum_b;
  logic [SUMA_W-1:0] sum_a;
  logic [NW-1:0]     cnt_n;

  logic [7:0] res_r;
  logic [7:0] res_g;
  logic [7:0] res_b;
  logic [7:0] res_a;

  logic in_accept;

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  always_comb begin
    if (src_width == 8'd0) begin
      sw = SW_W'(1);
    end else if (32'(src_width) > SRC_DIM) begin
      sw = SW_W'(SRC_DIM);
    end else begin
      sw = SW_W'(src_width);
    end
    if (src_height == 8'd0) begin
      sh = SW_W'(1);
    end else if (32'(src_height) > SRC_DIM) begin
      sh = SW_W'(SRC_DIM);
    end else begin
      sh = SW_W'(src_height);
    end
    if (dst_width == 9'd0) begin
      dw = DW_W'(1);
    end else if (32'(dst_width) > DST_DIM) begin
      dw = DW_W'(DST_DIM);
    end else begin
      dw = DW_W'(dst_width);
    end
    if (dst_height == 9'd0) begin
      dh = DW_W'(1);
    end else if (32'(dst_height) > DST_DIM) begin
      dh = DW_W'(DST_DIM);
    end else begin
      dh = DW_W'(dst_height);
    end
  end

  always_comb begin
    mul_a = {1'b0, col_r};
    mul_b = sw;
    case (op)
      OP_X0: begin
        mul_a = {1'b0, col_r};
        mul_b = sw;
      end
      OP_X1: begin
        mul_a = {1'b0, col_r} + 9'd1;
        mul_b = sw;
      end
      OP_Y0: begin
        mul_a = {1'b0, row_r};
        mul_b = sh;
      end
      OP_Y1: begin
        mul_a = {1'b0, row_r} + 9'd1;
        mul_b = sh;
      end
      default: begin
        mul_a = {1'b0, col_r};
        mul_b = sw;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    case (op)
      OP_X0, OP_X1: begin
        dividend = DVW'(prod);
        divisor  = DSW'(dw);
      end
      OP_Y0, OP_Y1: begin
        dividend = DVW'(prod);
        divisor  = DSW'(dh);
      end
      OP_R: begin
        dividend = DVW'(sum_r);
        divisor  = DSW'(sum_a);
      end
      OP_G: begin
        dividend = DVW'(sum_g);
        divisor  = DSW'(sum_a);
      end
      OP_B: begin
        dividend = DVW'(sum_b);
        divisor  = DSW'(sum_a);
      end
      OP_A: begin
        dividend = DVW'(sum_a);
        divisor  = DSW'(cnt_n);
      end
      default: begin
        dividend = DVW'(prod);
        divisor  = DSW'(dw);
      end
    endcase
  end

  assign rem_sh = {div_rem, div_q[DVW-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_d});

  assign x1_raw = (q_x1 <= q_x0) ? (q_x0 + DVW'(1)) : q_x1;
  assign y1_raw = (q_y1 <= q_y0) ? (q_y0 + DVW'(1)) : q_y1;
  assign x1_lim = (x1_raw > DVW'(sw)) ? sw : x1_raw[SW_W-1:0];
  assign y1_lim = (y1_raw > DVW'(sh)) ? sh : y1_raw[SW_W-1:0];

  assign rd_addr = AW'(AW'(sy) * AW'(SRC_DIM) + AW'(sx));
  assign wr_addr = AW'(AW'(in_item.row) * AW'(SRC_DIM) + AW'(in_item.col));
  assign wr_en   = in_accept && (in_item.mode == MODE_LOAD) &&
                   (32'(in_item.col) < SRC_DIM) && (32'(in_item.row) < SRC_DIM);
  assign wr_word = {in_item.alpha, in_item.blue, in_item.green, in_item.red};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      op         <= OP_X0;
      out_valid  <= 1'b0;
      rd_valid   <= 1'b0;
      src_width  <= 8'd128;
      src_height <= 8'd128;
      dst_width  <= 9'd32;
      dst_height <= 9'd32;
    end else begin
      rd_valid <= (state == ST_WALK);

      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_width  <= cfg_data[7:0];
          REG_SRC_HEIGHT: src_height <= cfg_data[7:0];
          REG_DST_WIDTH:  dst_width  <= cfg_data;
          REG_DST_HEIGHT: dst_height <= cfg_data;
          default: begin
          end
        endcase
      end

      if (out_valid && out_ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      if (rd_valid) begin
        sum_r <= sum_r + SUMC_W'(16'(rd_data[7:0]) * 16'(rd_data[31:24]));
        sum_g <= sum_g + SUMC_W'(16'(rd_data[15:8]) * 16'(rd_data[31:24]));
        sum_b <= sum_b + SUMC_W'(16'(rd_data[23:16]) * 16'(rd_data[31:24]));
        sum_a <= sum_a + SUMA_W'(rd_data[31:24]);
        cnt_n <= cnt_n + NW'(1);
      end

      case (state)
        ST_IDLE: begin
          if (in_accept && (in_item.mode == MODE_COMPUTE)) begin
            col_r <= in_item.col;
            row_r <= in_item.row;
            sum_r <= '0;
            sum_g <= '0;
            sum_b <= '0;
            sum_a <= '0;
            cnt_n <= '0;
            op    <= OP_X0;
            state <= ST_DIV_LOAD;
          end
        end
        ST_DIV_LOAD: begin
          div_q   <= dividend;
          div_d   <= divisor;
          div_rem <= '0;
          div_cnt <= '0;
          state   <= ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          if (rem_ge) begin
            div_rem <= DSW'(rem_sh - {1'b0, div_d});
          end else begin
            div_rem <= rem_sh[DSW-1:0];
          end
          div_q   <= {div_q[DVW-2:0], rem_ge};
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(DVW - 1)) begin
            state <= ST_DIV_DONE;
          end
        end
        ST_DIV_DONE: begin
          case (op)
            OP_X0: begin
              q_x0  <= div_q;
              op    <= OP_X1;
              state <= ST_DIV_LOAD;
            end
            OP_X1: begin
              q_x1  <= div_q;
              op    <= OP_Y0;
              state <= ST_DIV_LOAD;
            end
            OP_Y0: begin
              q_y0  <= div_q;
              op    <= OP_Y1;
              state <= ST_DIV_LOAD;
            end
            OP_Y1: begin
              q_y1  <= div_q;
              state <= ST_SPAN;
            end
            OP_R: begin
              res_r <= div_q[7:0];
              op    <= OP_G;
              state <= ST_DIV_LOAD;
            end
            OP_G: begin
              res_g <= div_q[7:0];
              op    <= OP_B;
              state <= ST_DIV_LOAD;
            end
            OP_B: begin
              res_b <= div_q[7:0];
              op    <= OP_A;
              state <= ST_DIV_LOAD;
            end
            OP_A: begin
              res_a <= div_q[7:0];
              state <= ST_FINISH;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_SPAN: begin
          if ((q_x0 >= DVW'(sw)) || (q_y0 >= DVW'(sh))) begin
            res_r <= '0;
            res_g <= '0;
            res_b <= '0;
            res_a <= '0;
            state <= ST_FINISH;
          end else begin
            x0    <= q_x0[SW_W-1:0];
            x1    <= x1_lim;
            y1    <= y1_lim;
            sx    <= q_x0[SW_W-1:0];
            sy    <= q_y0[SW_W-1:0];
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (SW_W'(sx + SW_W'(1)) == x1) begin
            sx <= x0;
            if (SW_W'(sy + SW_W'(1)) == y1) begin
              state <= ST_DRAIN;
            end else begin
              sy <= sy + SW_W'(1);
            end
          end else begin
            sx <= sx + SW_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_TEST;
        end
        ST_TEST: begin
          if (sum_a == '0) begin
            res_r <= '0;
            res_g <= '0;
            res_b <= '0;
            res_a <= '0;
            state <= ST_FINISH;
          end else begin
            op    <= OP_R;
            state <= ST_DIV_LOAD;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_item.out_red   <= res_r;
            out_item.out_green <= res_g;
            out_item.out_blue  <= res_b;
            out_item.out_alpha <= res_a;
            out_valid          <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
